[rtl/rtt_statistics_accumulator_defines.svh]
// ----------------------------------------------------------------------------
// RTT statistics accumulator assertion macros
// Shared concurrent assertion wrappers on clock and reset.
// ----------------------------------------------------------------------------
`ifndef RTT_STATISTICS_ACCUMULATOR_DEFINES_SVH
`define RTT_STATISTICS_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define RTTA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RTTA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rtta_pkg.sv]
// ----------------------------------------------------------------------------
// RTT statistics accumulator package
// Widths, reset values and register indexes shared by the block.
// ----------------------------------------------------------------------------
package rtta_pkg;

   localparam int RTT_BITS_DEFAULT = 24;
   localparam int CNT_BITS         = 32;
   localparam int SUM_BITS         = 48;
   localparam int SQ_BITS          = 63;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int WAIT_LIMIT_RESET = 2000000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WAIT_LIMIT       = 2'd0,
      CSR_THRESHOLD_ENABLE = 2'd1,
      CSR_THRESHOLD        = 2'd2
   } csr_index_type;

endpackage

[rtl/rtta_req_if.sv]
// ----------------------------------------------------------------------------
// RTT statistics request channel
// Valid/ready channel carrying one event: probe sent or echo reply.
// ----------------------------------------------------------------------------
interface rtta_req_if #(
   parameter int RTT_BITS = rtta_pkg::RTT_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [RTT_BITS-1:0] rtt_us;

   modport source (output valid, output req_type, output rtt_us, input ready);
   modport sink   (input valid, input req_type, input rtt_us, output ready);
endinterface

[rtl/rtta_rsp_if.sv]
// ----------------------------------------------------------------------------
// RTT statistics result channel
// Valid/ready channel carrying the statistics after each event.
// ----------------------------------------------------------------------------
interface rtta_rsp_if #(
   parameter int RTT_BITS = rtta_pkg::RTT_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic                         accepted;
   logic [rtta_pkg::CNT_BITS-1:0] sent_count;
   logic [rtta_pkg::CNT_BITS-1:0] ok_count;
   logic [RTT_BITS-1:0]          rtt_minimum;
   logic [RTT_BITS-1:0]          rtt_maximum;
   logic [rtta_pkg::SUM_BITS-1:0] rtt_total;
   logic [rtta_pkg::SQ_BITS-1:0]  rtt_square_total;
   logic [rtta_pkg::CNT_BITS-1:0] exceed_count;

   modport source (
      output valid, output accepted, output sent_count, output ok_count,
      output rtt_minimum, output rtt_maximum, output rtt_total,
      output rtt_square_total, output exceed_count, input ready
   );
   modport sink (
      input valid, input accepted, input sent_count, input ok_count,
      input rtt_minimum, input rtt_maximum, input rtt_total,
      input rtt_square_total, input exceed_count, output ready
   );
endinterface

[rtl/rtta_in_stage.sv]
// ----------------------------------------------------------------------------
// RTT statistics input stage
// Registers the request and its saturated square.
// ----------------------------------------------------------------------------
module rtta_in_stage #(
   parameter int RTT_BITS = rtta_pkg::RTT_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   rtta_req_if.sink                   req_port,
   input  logic                       advance,
   output logic                       stage_valid,
   output logic                       stage_type,
   output logic [RTT_BITS-1:0]        stage_rtt,
   output logic [rtta_pkg::SQ_BITS-1:0] stage_sq
);
   localparam int SQ_BITS = rtta_pkg::SQ_BITS;

   logic                   valid_ff, valid_in;
   logic                   type_ff;
   logic [RTT_BITS-1:0]    rtt_ff;
   logic [SQ_BITS-1:0]     sq_ff, sq_in;
   logic [2*RTT_BITS-1:0]  product;
   logic [SQ_BITS:0]       product_wide;
   logic                   load;

   assign req_port.ready = advance | ~valid_ff;
   assign load           = req_port.valid & req_port.ready;
   assign valid_in       = req_port.ready ? req_port.valid : valid_ff;

   assign product      = req_port.rtt_us * req_port.rtt_us;
   assign product_wide = (SQ_BITS + 1)'(product);
   assign sq_in        = product_wide[SQ_BITS] ? '1 : product_wide[SQ_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         type_ff <= req_port.req_type;
         rtt_ff  <= req_port.rtt_us;
         sq_ff   <= sq_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_type  = type_ff;
   assign stage_rtt   = rtt_ff;
   assign stage_sq    = sq_ff;
endmodule

[rtl/rtta_core.sv]
// ----------------------------------------------------------------------------
// RTT statistics core
// Accept check, statistics update and result register.
// ----------------------------------------------------------------------------
`include "rtt_statistics_accumulator_defines.svh"

module rtta_core #(
   parameter int RTT_BITS = rtta_pkg::RTT_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [RTT_BITS-1:0]          wait_limit,
   input  logic                         threshold_enable,
   input  logic [RTT_BITS-1:0]          threshold,
   input  logic                         stage_valid,
   input  logic                         stage_type,
   input  logic [RTT_BITS-1:0]          stage_rtt,
   input  logic [rtta_pkg::SQ_BITS-1:0] stage_sq,
   output logic                         advance,
   rtta_rsp_if.source                   rsp_port
);
   localparam int CNT_BITS = rtta_pkg::CNT_BITS;
   localparam int SUM_BITS = rtta_pkg::SUM_BITS;
   localparam int SQ_BITS  = rtta_pkg::SQ_BITS;

   logic [CNT_BITS-1:0] sent_ff, sent_in;
   logic [CNT_BITS-1:0] acc_ff, acc_in;
   logic [CNT_BITS-1:0] over_ff, over_in;
   logic [RTT_BITS-1:0] last_ff, last_in;
   logic [RTT_BITS-1:0] min_ff, min_in;
   logic [RTT_BITS-1:0] max_ff, max_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [SQ_BITS-1:0]  sq_ff, sq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                ok_ff;

   logic                fire, first, ok, over;
   logic [RTT_BITS:0]   double_last;
   logic [SUM_BITS:0]   sum_wide;
   logic [SQ_BITS:0]    sq_wide;

   assign advance     = ~rsp_valid_ff | rsp_port.ready;
   assign fire        = stage_valid & advance;
   assign first       = (acc_ff == '0);
   assign double_last = {last_ff, 1'b0};
   assign ok          = stage_type &
                        (first ? (stage_rtt < wait_limit)
                               : ({1'b0, stage_rtt} < double_last));
   assign over        = ~first & threshold_enable & (stage_rtt > threshold);
   assign sum_wide    = {1'b0, sum_ff} + (SUM_BITS + 1)'(stage_rtt);
   assign sq_wide     = {1'b0, sq_ff} + {1'b0, stage_sq};

   always_comb begin
      sent_in = sent_ff;
      acc_in  = acc_ff;
      over_in = over_ff;
      last_in = last_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      if (!stage_type) begin
         if (sent_ff != '1) begin
            sent_in = sent_ff + CNT_BITS'(1);
         end
      end else if (ok) begin
         if (first) begin
            min_in = stage_rtt;
            max_in = stage_rtt;
         end else begin
            if (stage_rtt > max_ff) begin
               max_in = stage_rtt;
            end
            if (stage_rtt < min_ff) begin
               min_in = stage_rtt;
            end
         end
         if (over && over_ff != '1) begin
            over_in = over_ff + CNT_BITS'(1);
         end
         if (acc_ff != '1) begin
            acc_in = acc_ff + CNT_BITS'(1);
         end
         sum_in  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
         sq_in   = sq_wide[SQ_BITS] ? '1 : sq_wide[SQ_BITS-1:0];
         last_in = stage_rtt;
      end
   end

   assign rsp_valid_in = fire | (rsp_valid_ff & ~rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sent_ff      <= '0;
         acc_ff       <= '0;
         over_ff      <= '0;
         last_ff      <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            sent_ff <= sent_in;
            acc_ff  <= acc_in;
            over_ff <= over_in;
            last_ff <= last_in;
            min_ff  <= min_in;
            max_ff  <= max_in;
            sum_ff  <= sum_in;
            sq_ff   <= sq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         ok_ff <= ok;
      end
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.accepted         = ok_ff;
   assign rsp_port.sent_count       = sent_ff;
   assign rsp_port.ok_count         = acc_ff;
   assign rsp_port.rtt_minimum      = min_ff;
   assign rsp_port.rtt_maximum      = max_ff;
   assign rsp_port.rtt_total        = sum_ff;
   assign rsp_port.rtt_square_total = sq_ff;
   assign rsp_port.exceed_count     = over_ff;

   `RTTA_ASSERT_NOW(a_min_le_max, acc_ff != '0, min_ff <= max_ff, "minimum above maximum")
   `RTTA_ASSERT_NEXT(a_acc_sticky, acc_ff != '0, acc_ff != '0, "accepted count returned to zero")
   `RTTA_ASSERT_NEXT(a_probe_keeps_acc, fire && !stage_type, acc_ff == $past(acc_ff), "probe changed accepted count")
   `RTTA_ASSERT_NOW(a_ok_has_count, rsp_valid_ff && ok_ff, acc_ff != '0, "accepted result with zero count")
endmodule

[rtl/rtt_statistics_accumulator.sv]
// ----------------------------------------------------------------------------
// RTT statistics accumulator
// Tracks probe count and min, max, sum and sum of squares of accepted RTTs.
// ----------------------------------------------------------------------------
// Path: input register, update logic, result register, then rsp_port.
// Throughput: one request per cycle while the result is not stalled.
// A stalled result holds the pipeline; a new request still enters an empty stage.
// Reset (synchronous) clears all counters and statistics and restores registers
// to their defaults.
module rtt_statistics_accumulator #(
   parameter int RTT_BITS = rtta_pkg::RTT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   rtta_req_if.sink                            req_port,
   rtta_rsp_if.source                          rsp_port,
   input  logic                                csr_write,
   input  logic [rtta_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [RTT_BITS-1:0]                 csr_data
);
   logic [RTT_BITS-1:0]          wait_limit_ff;
   logic                         threshold_enable_ff;
   logic [RTT_BITS-1:0]          threshold_ff;
   logic                         advance;
   logic                         stage_valid;
   logic                         stage_type;
   logic [RTT_BITS-1:0]          stage_rtt;
   logic [rtta_pkg::SQ_BITS-1:0] stage_sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_limit_ff       <= RTT_BITS'(rtta_pkg::WAIT_LIMIT_RESET);
         threshold_enable_ff <= 1'b0;
         threshold_ff        <= '0;
      end else if (csr_write) begin
         case (csr_index)
            rtta_pkg::CSR_WAIT_LIMIT:       wait_limit_ff       <= csr_data;
            rtta_pkg::CSR_THRESHOLD_ENABLE: threshold_enable_ff <= csr_data[0];
            rtta_pkg::CSR_THRESHOLD:        threshold_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   rtta_in_stage #(.RTT_BITS(RTT_BITS)) u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_type  (stage_type),
      .stage_rtt   (stage_rtt),
      .stage_sq    (stage_sq)
   );

   rtta_core #(.RTT_BITS(RTT_BITS)) u_core (
      .clock            (clock),
      .reset            (reset),
      .wait_limit       (wait_limit_ff),
      .threshold_enable (threshold_enable_ff),
      .threshold        (threshold_ff),
      .stage_valid      (stage_valid),
      .stage_type       (stage_type),
      .stage_rtt        (stage_rtt),
      .stage_sq         (stage_sq),
      .advance          (advance),
      .rsp_port         (rsp_port)
   );
endmodule

[dv/rtt_statistics_accumulator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTT statistics accumulator testbench
// Sends probe and echo-reply requests over the valid/ready channels and
// predicts the statistics that each request produces. Every result is
// compared field by field with the oldest prediction. The run steps through
// register settings and idle/stall patterns, including a long receiver
// hold-off and the wait-limit, doubling and threshold boundaries.
// ----------------------------------------------------------------------------
module rtt_statistics_accumulator_tb;

   localparam int RTT_BITS = 24;
   localparam int RESULT_LATENCY = 2;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int CNT_BITS = rtta_pkg::CNT_BITS;
   localparam int SUM_BITS = rtta_pkg::SUM_BITS;
   localparam int SQ_BITS = rtta_pkg::SQ_BITS;
   localparam int CSR_INDEX_BITS = rtta_pkg::CSR_INDEX_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam logic [RTT_BITS-1:0] RTT_MAX = '1;

   typedef enum bit {
      EVENT_PROBE = 1'b0,
      EVENT_REPLY = 1'b1
   } event_kind_type;

   typedef struct packed {
      logic                accepted;
      logic [CNT_BITS-1:0] sent_count;
      logic [CNT_BITS-1:0] ok_count;
      logic [RTT_BITS-1:0] rtt_minimum;
      logic [RTT_BITS-1:0] rtt_maximum;
      logic [SUM_BITS-1:0] rtt_total;
      logic [SQ_BITS-1:0]  rtt_square_total;
      logic [CNT_BITS-1:0] exceed_count;
   } rtt_stats_type;

   class rtt_stats_tracker;
      logic [RTT_BITS-1:0] wait_limit = RTT_BITS'(rtta_pkg::WAIT_LIMIT_RESET);
      logic                exceed_on = 1'b0;
      logic [RTT_BITS-1:0] exceed_level = '0;
      logic [RTT_BITS-1:0] last_rtt = '0;
      rtt_stats_type       totals = '0;
      rtt_stats_type       pending_stats[$];
      int                  mismatches;
      int                  checked;
      int                  requests;

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [RTT_BITS-1:0] value);
         case (index)
            rtta_pkg::CSR_WAIT_LIMIT:       wait_limit = value;
            rtta_pkg::CSR_THRESHOLD_ENABLE: exceed_on = value[0];
            rtta_pkg::CSR_THRESHOLD:        exceed_level = value;
            default: ;
         endcase
      endfunction

      function void note_request(event_kind_type kind, logic [RTT_BITS-1:0] rtt);
         logic            first;
         logic            ok;
         logic [SUM_BITS:0] sum_next;
         logic [SQ_BITS:0]  sq_next;
         requests++;
         totals.accepted = 1'b0;
         if (kind == EVENT_PROBE) begin
            if (totals.sent_count != '1) totals.sent_count++;
         end else begin
            first = (totals.ok_count == 0);
            ok = first ? (rtt < wait_limit) : ({1'b0, rtt} < {last_rtt, 1'b0});
            if (ok) begin
               if (first) begin
                  totals.rtt_minimum = rtt;
                  totals.rtt_maximum = rtt;
               end else begin
                  if (rtt > totals.rtt_maximum) totals.rtt_maximum = rtt;
                  if (rtt < totals.rtt_minimum) totals.rtt_minimum = rtt;
                  if (exceed_on && rtt > exceed_level && totals.exceed_count != '1)
                     totals.exceed_count++;
               end
               sum_next = {1'b0, totals.rtt_total} + (SUM_BITS + 1)'(rtt);
               totals.rtt_total = sum_next[SUM_BITS] ? '1 : sum_next[SUM_BITS-1:0];
               sq_next = {1'b0, totals.rtt_square_total} +
                         (SQ_BITS + 1)'(rtt) * (SQ_BITS + 1)'(rtt);
               totals.rtt_square_total = sq_next[SQ_BITS] ? '1 : sq_next[SQ_BITS-1:0];
               if (totals.ok_count != '1) totals.ok_count++;
               last_rtt = rtt;
               totals.accepted = 1'b1;
            end
         end
         pending_stats.push_back(totals);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
         if (seen !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
            mismatches++;
         end
      endfunction

      function void check_result(rtt_stats_type seen);
         rtt_stats_type want;
         if (pending_stats.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, seen);
            mismatches++;
            return;
         end
         want = pending_stats.pop_front();
         checked++;
         compare_field("accepted", 64'(want.accepted), 64'(seen.accepted));
         compare_field("sent_count", 64'(want.sent_count), 64'(seen.sent_count));
         compare_field("ok_count", 64'(want.ok_count), 64'(seen.ok_count));
         compare_field("rtt_minimum", 64'(want.rtt_minimum), 64'(seen.rtt_minimum));
         compare_field("rtt_maximum", 64'(want.rtt_maximum), 64'(seen.rtt_maximum));
         compare_field("rtt_total", 64'(want.rtt_total), 64'(seen.rtt_total));
         compare_field("rtt_square_total", 64'(want.rtt_square_total),
                       64'(seen.rtt_square_total));
         compare_field("exceed_count", 64'(want.exceed_count), 64'(seen.exceed_count));
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [RTT_BITS-1:0]       csr_data;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_requests;
   int hold_off_seen;
   int hold_off_left;

   rtt_stats_tracker stats = new();

   rtta_req_if #(.RTT_BITS(RTT_BITS)) req_bus ();
   rtta_rsp_if #(.RTT_BITS(RTT_BITS)) rsp_bus ();

   rtt_statistics_accumulator #(.RTT_BITS(RTT_BITS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus.sink),
      .rsp_port  (rsp_bus.source),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("%0t: timeout with %0d results outstanding", $time,
               stats.pending_stats.size());
      $display("Mismatches found");
      $finish;
   end

   // drive ready: hold off first, else stall at random
   initial begin
      rsp_bus.ready = 1'b0;
      hold_off_seen = 0;
      hold_off_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_seen != hold_off_requests) begin
            hold_off_seen = hold_off_requests;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_off_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      rtt_stats_type seen;
      seen = {rsp_bus.accepted, rsp_bus.sent_count, rsp_bus.ok_count,
              rsp_bus.rtt_minimum, rsp_bus.rtt_maximum, rsp_bus.rtt_total,
              rsp_bus.rtt_square_total, rsp_bus.exceed_count};
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         stats.check_result(seen);
   end

   task automatic send_request(event_kind_type kind, logic [RTT_BITS-1:0] rtt);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.req_type = kind;
      req_bus.rtt_us = rtt;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      stats.note_request(kind, rtt);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (stats.pending_stats.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [RTT_BITS-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      stats.write_register(index, value);
   endtask

   // mostly replies inside the acceptance window around the last RTT
   function automatic logic [RTT_BITS-1:0] pick_reply_rtt();
      int unsigned last;
      int unsigned twice;
      int unsigned low;
      int unsigned high;
      int unsigned limit;
      limit = 32'(RTT_MAX);
      last = 32'(stats.last_rtt);
      twice = last * 2;
      low = (last + 1) / 2;
      high = (twice > limit) ? limit : twice - 1;
      if (last == 0) return RTT_BITS'($urandom);
      case ($urandom_range(9))
         0: return RTT_BITS'($urandom);
         1: return (twice <= limit) ? RTT_BITS'(twice) : RTT_BITS'($urandom);
         2: return RTT_BITS'(high);
         default: return $urandom_range(1) ? RTT_BITS'($urandom_range(last, low))
                                           : RTT_BITS'($urandom_range(high, last));
      endcase
   endfunction

   task automatic run_random_phase(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 30) send_request(EVENT_PROBE, RTT_BITS'($urandom));
         else send_request(EVENT_REPLY, pick_reply_rtt());
      end
   endtask

   initial begin
      hold_off_requests = 0;
      req_bus.valid = 1'b0;
      req_bus.req_type = EVENT_PROBE;
      req_bus.rtt_us = '0;
      csr_write = 1'b0;
      csr_index = rtta_pkg::CSR_WAIT_LIMIT;
      csr_data = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default wait limit: reject at and above it
      send_request(EVENT_PROBE, RTT_MAX);
      send_request(EVENT_REPLY, RTT_MAX);
      send_request(EVENT_REPLY, RTT_BITS'(rtta_pkg::WAIT_LIMIT_RESET));
      send_request(EVENT_PROBE, '0);
      wait_for_results();
      write_register(rtta_pkg::CSR_WAIT_LIMIT, '0);
      send_request(EVENT_REPLY, '0);
      send_request(EVENT_REPLY, 24'd1);
      wait_for_results();
      write_register(rtta_pkg::CSR_WAIT_LIMIT, RTT_MAX);
      write_register(rtta_pkg::CSR_THRESHOLD_ENABLE, 24'hABCDE1);
      write_register(rtta_pkg::CSR_THRESHOLD, '0);
      write_register(CSR_UNUSED, RTT_MAX);
      send_request(EVENT_REPLY, RTT_MAX);
      send_request(EVENT_REPLY, RTT_MAX - 1'b1);
      send_request(EVENT_REPLY, RTT_MAX);
      send_request(EVENT_PROBE, 24'h5A5A5A);
      wait_for_results();
      write_register(rtta_pkg::CSR_THRESHOLD, 24'd9999);
      send_request(EVENT_REPLY, 24'd5000);
      send_request(EVENT_REPLY, 24'd10000);
      send_request(EVENT_REPLY, 24'd9999);
      send_request(EVENT_REPLY, 24'd15000);
      send_request(EVENT_REPLY, 24'd7500);
      send_request(EVENT_PROBE, 24'hA5A5A5);
      wait_for_results();

      // no idling, then a long receiver hold-off under full load
      write_register(rtta_pkg::CSR_THRESHOLD, stats.last_rtt);
      run_random_phase(100);
      hold_off_requests++;
      run_random_phase(20);
      wait_for_results();

      // sender idle; enable masked off
      write_register(rtta_pkg::CSR_THRESHOLD_ENABLE, 24'hFFFFFE);
      write_register(rtta_pkg::CSR_THRESHOLD, RTT_MAX);
      send_idle_pct = 64;
      run_random_phase(100);
      wait_for_results();

      // receiver stalls
      write_register(rtta_pkg::CSR_THRESHOLD_ENABLE, 24'd1);
      write_register(rtta_pkg::CSR_THRESHOLD, stats.last_rtt);
      write_register(rtta_pkg::CSR_WAIT_LIMIT, RTT_BITS'($urandom));
      send_idle_pct = 0;
      recv_stall_pct = 64;
      run_random_phase(100);
      wait_for_results();

      // both sides idle
      write_register(rtta_pkg::CSR_THRESHOLD, '0);
      send_idle_pct = 19;
      recv_stall_pct = 19;
      run_random_phase(100);
      wait_for_results();

      // accept a zero RTT: nothing is accepted afterwards
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_request(EVENT_REPLY, '0);
      send_request(EVENT_REPLY, 24'd1);
      send_request(EVENT_REPLY, '0);
      send_request(EVENT_PROBE, RTT_MAX);
      wait_for_results();
      repeat (RESULT_LATENCY + 4) @(posedge clock);

      $display("Run covered %0d requests, %0d results checked, final ok_count %0d",
               stats.requests, stats.checked, stats.totals.ok_count);
      $display("and exceed_count %0d across four idle patterns and a receiver hold-off",
               stats.totals.exceed_count);
      if (stats.mismatches == 0 && stats.pending_stats.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/rtta_pkg.sv
rtl/rtta_req_if.sv
rtl/rtta_rsp_if.sv
rtl/rtta_in_stage.sv
rtl/rtta_core.sv
rtl/rtt_statistics_accumulator.sv
dv/rtt_statistics_accumulator_tb.sv
